>>> rtl/matrix3x3_inverse_defines.svh
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shared property wrappers for the checker files of the inverse block.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// condition must hold at every edge out of reset
`define M3INV_ASSERT_NOW(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define M3INV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants of the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	// one lane per matrix entry
	localparam int NLANE = 9;

	// per-item control carried through the divider stages
	typedef struct packed {
		logic valid;
		logic singular;
	} m3inv_ctl_t;

endpackage

>>> rtl/m3inv_if.sv
// ----------------------------------------------------------------------------
// m3inv stream interfaces
// Valid/ready channels for the input matrix and the inverse result.
// ----------------------------------------------------------------------------
interface m3inv_in_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

	modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
	modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3inv_out_if #(parameter int DATA_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
	logic singular;
	logic clipped;

	modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, singular, clipped, input ready);
	modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21,
		inv22, singular, clipped, output ready);
endinterface

>>> rtl/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 fixed-point inverse by adjugate over determinant, fully pipelined.
//
//   channel | dir | payload
//   in      | in  | a00..a22, signed Q(DW-FB).FB
//   out     | out | inv00..inv22 saturated, singular, clipped
//
// One matrix per cycle while the output does not stall. Stages: five
// front, one divider setup, DATA_WIDTH + 1 division (overflow check,
// then one quotient bit each), one saturation/output. Reset clears only
// the valid/singular control bits. A stalled output backs up stage by
// stage; empty stages keep filling, so ready drops only when full.
// ----------------------------------------------------------------------------
module matrix3x3_inverse import m3inv_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	m3inv_in_if.sink    in,
	m3inv_out_if.source out
);
	localparam int DW   = DATA_WIDTH;
	localparam int CW   = 2 * DW + 1;
	localparam int DETW = 3 * DW + 3;
	localparam int NW   = CW + 2 * FRAC_BITS;
	localparam int RW   = ((NW > DETW + DW) ? NW : DETW + DW) + 1;
	localparam int NSTEP = DW + 1;

	logic signed [DW-1:0] a [NLANE];
	logic signed [CW-1:0] cof [NLANE];
	logic signed [DETW-1:0] det;
	logic fr_valid, fr_ready;

	// chain between division stages, index 0 is the setup stage
	m3inv_ctl_t      ctl_c [NSTEP+1];
	logic            rdy_c [NSTEP+1];
	logic [RW-1:0]   r_c [NSTEP+1][NLANE];
	logic [DW-1:0]   q_c [NSTEP+1][NLANE];
	logic            neg_c [NSTEP+1][NLANE];
	logic            ovf_c [NSTEP+1][NLANE];
	logic [DETW-1:0] d_c [NSTEP+1];

	logic out_en;
	logic out_valid_q;
	logic signed [DW-1:0] inv_q [NLANE];
	logic sing_q, clip_q;
	logic [NLANE-1:0] lane_clip;
	logic [DW-1:0] lane_val [NLANE];

	assign a[0] = in.a00;
	assign a[1] = in.a01;
	assign a[2] = in.a02;
	assign a[3] = in.a10;
	assign a[4] = in.a11;
	assign a[5] = in.a12;
	assign a[6] = in.a20;
	assign a[7] = in.a21;
	assign a[8] = in.a22;

	m3inv_front #(.DW(DW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.a        (a),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.cof      (cof),
		.det      (det)
	);

	// setup stage: magnitudes, signs, scaled numerators
	assign fr_ready = !ctl_c[0].valid || rdy_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (fr_ready) begin
			ctl_c[0].valid <= fr_valid;
			ctl_c[0].singular <= (det == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (fr_ready) d_c[0] <= det[DETW-1] ? DETW'(-det) : DETW'(det);
	end

	for (genvar k = 0; k < NLANE; k++) begin : g_setup
		logic [CW-1:0] cmag;
		assign cmag = cof[k][CW-1] ? CW'(-cof[k]) : CW'(cof[k]);
		always_ff @(posedge clk) begin
			if (fr_ready) begin
				r_c[0][k] <= RW'(cmag) << (2 * FRAC_BITS);
				q_c[0][k] <= '0;
				neg_c[0][k] <= cof[k][CW-1] ^ det[DETW-1];
				ovf_c[0][k] <= 1'b0;
			end
		end
	end

	// division stages: overflow check first, then bits DW-1 down to 0
	for (genvar s = 0; s < NSTEP; s++) begin : g_div
		m3inv_div_step #(
			.DW  (DW),
			.RW  (RW),
			.DETW(DETW),
			.BIT (DW - s),
			.TOP (s == 0)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl_c[s]),
			.in_ready (rdy_c[s]),
			.r_in     (r_c[s]),
			.q_in     (q_c[s]),
			.neg_in   (neg_c[s]),
			.ovf_in   (ovf_c[s]),
			.d_in     (d_c[s]),
			.ctl_out  (ctl_c[s+1]),
			.out_ready(rdy_c[s+1]),
			.r_out    (r_c[s+1]),
			.q_out    (q_c[s+1]),
			.neg_out  (neg_c[s+1]),
			.ovf_out  (ovf_c[s+1]),
			.d_out    (d_c[s+1])
		);
	end

	// saturation and sign
	for (genvar k = 0; k < NLANE; k++) begin : g_sat
		logic [DW-1:0] lim;
		logic [DW-1:0] mag;
		logic [RW-1:0] unused_r;
		assign unused_r = r_c[NSTEP][k];
		assign lim = neg_c[NSTEP][k] ? (DW'(1) << (DW - 1)) : ((DW'(1) << (DW - 1)) - DW'(1));
		assign lane_clip[k] = ovf_c[NSTEP][k] || (q_c[NSTEP][k] > lim);
		assign mag = lane_clip[k] ? lim : q_c[NSTEP][k];
		assign lane_val[k] = neg_c[NSTEP][k] ? (~mag + DW'(1)) : mag;
	end

	// output register
	assign out_en = !out_valid_q || out.ready;
	assign rdy_c[NSTEP] = out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= ctl_c[NSTEP].valid;
		end
	end

	// lane (i,j) holds cofactor C[i][j] and lands at inverse (j,i)
	for (genvar k = 0; k < NLANE; k++) begin : g_out
		localparam int T = (k % 3) * 3 + (k / 3);
		always_ff @(posedge clk) begin
			if (out_en) inv_q[T] <= ctl_c[NSTEP].singular ? '0 : $signed(lane_val[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			sing_q <= ctl_c[NSTEP].singular;
			clip_q <= !ctl_c[NSTEP].singular && (|lane_clip);
		end
	end

	assign out.valid = out_valid_q;
	assign out.inv00 = inv_q[0];
	assign out.inv01 = inv_q[1];
	assign out.inv02 = inv_q[2];
	assign out.inv10 = inv_q[3];
	assign out.inv11 = inv_q[4];
	assign out.inv12 = inv_q[5];
	assign out.inv20 = inv_q[6];
	assign out.inv21 = inv_q[7];
	assign out.inv22 = inv_q[8];
	assign out.singular = sing_q;
	assign out.clipped = clip_q;
endmodule

>>> rtl/m3inv_front.sv
// ----------------------------------------------------------------------------
// m3inv_front
// Cofactor and determinant pipeline: products, cofactors, split partial
// products, partial sums and the determinant, one register stage each.
// ----------------------------------------------------------------------------
module m3inv_front import m3inv_pkg::*; #(
	parameter int DW = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [DW-1:0]    a [NLANE],
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [2*DW:0]    cof [NLANE],
	output logic signed [3*DW+2:0]  det
);
	localparam int PW = 2 * DW;
	localparam int CW = 2 * DW + 1;
	localparam int TW = 3 * DW + 1;
	localparam int DETW = 3 * DW + 3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic signed [PW-1:0] pa_s1 [NLANE];
	logic signed [PW-1:0] pb_s1 [NLANE];
	logic signed [DW-1:0] col_s1 [3];
	logic signed [CW-1:0] c_s2 [NLANE];
	logic signed [DW-1:0] col_s2 [3];
	logic signed [CW-1:0] c_s3 [NLANE];
	logic signed [CW-1:0] plo_s3 [3];
	logic signed [CW-1:0] phi_s3 [3];
	logic signed [CW-1:0] c_s4 [NLANE];
	logic signed [TW-1:0] t_s4 [3];
	logic signed [CW-1:0] c_s5 [NLANE];
	logic signed [DETW-1:0] det_s5;

	// stall chain: a stage moves when empty or when the next one moves
	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: the two minor products of each cofactor
	for (genvar k = 0; k < NLANE; k++) begin : g_prod
		localparam int I = k / 3;
		localparam int J = k % 3;
		localparam int R1 = (I == 0) ? 1 : 0;
		localparam int R2 = (I == 2) ? 1 : 2;
		localparam int C1 = (J == 0) ? 1 : 0;
		localparam int C2 = (J == 2) ? 1 : 2;
		always_ff @(posedge clk) begin
			if (en1) begin
				pa_s1[k] <= PW'(a[R1*3+C1]) * PW'(a[R2*3+C2]);
				pb_s1[k] <= PW'(a[R1*3+C2]) * PW'(a[R2*3+C1]);
			end
		end
	end

	// stage 2: signed cofactors
	for (genvar k = 0; k < NLANE; k++) begin : g_cof
		localparam bit ODD = (((k / 3) + (k % 3)) % 2) == 1;
		always_ff @(posedge clk) begin
			if (en2) begin
				if (ODD) c_s2[k] <= CW'(pb_s1[k]) - CW'(pa_s1[k]);
				else c_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
			end
		end
	end

	// column 0 entries travel along for the expansion
	for (genvar i = 0; i < 3; i++) begin : g_col
		always_ff @(posedge clk) begin
			if (en1) col_s1[i] <= a[i*3];
			if (en2) col_s2[i] <= col_s1[i];
		end
	end

	// stage 3: a[i][0] times cofactor, split into low and high halves
	for (genvar i = 0; i < 3; i++) begin : g_part
		always_ff @(posedge clk) begin
			if (en3) begin
				plo_s3[i] <= CW'(col_s2[i]) * CW'($signed({1'b0, c_s2[i*3][DW-1:0]}));
				phi_s3[i] <= CW'(col_s2[i]) * CW'($signed(c_s2[i*3][CW-1:DW]));
			end
		end
	end

	// stage 4: recombine halves
	for (genvar i = 0; i < 3; i++) begin : g_term
		always_ff @(posedge clk) begin
			if (en4) t_s4[i] <= (TW'(phi_s3[i]) <<< DW) + TW'(plo_s3[i]);
		end
	end

	// stage 5: determinant
	always_ff @(posedge clk) begin
		if (en5) det_s5 <= DETW'(t_s4[0]) + DETW'(t_s4[1]) + DETW'(t_s4[2]);
	end

	// cofactors ride along to the divider
	for (genvar k = 0; k < NLANE; k++) begin : g_carry
		always_ff @(posedge clk) begin
			if (en3) c_s3[k] <= c_s2[k];
			if (en4) c_s4[k] <= c_s3[k];
			if (en5) c_s5[k] <= c_s4[k];
		end
	end

	assign out_valid = v_s5;
	assign cof = c_s5;
	assign det = det_s5;
endmodule

>>> rtl/m3inv_div_step.sv
// ----------------------------------------------------------------------------
// m3inv_div_step
// One restoring-division stage for all nine lanes. The top stage only
// checks for a quotient at or above 2^DW; the others resolve bit BIT.
// ----------------------------------------------------------------------------
module m3inv_div_step import m3inv_pkg::*; #(
	parameter int DW   = 32,
	parameter int RW   = 200,
	parameter int DETW = 99,
	parameter int BIT  = 0,
	parameter bit TOP  = 1'b0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  m3inv_ctl_t       ctl_in,
	output logic             in_ready,
	input  logic [RW-1:0]    r_in [NLANE],
	input  logic [DW-1:0]    q_in [NLANE],
	input  logic             neg_in [NLANE],
	input  logic             ovf_in [NLANE],
	input  logic [DETW-1:0]  d_in,
	output m3inv_ctl_t       ctl_out,
	input  logic             out_ready,
	output logic [RW-1:0]    r_out [NLANE],
	output logic [DW-1:0]    q_out [NLANE],
	output logic             neg_out [NLANE],
	output logic             ovf_out [NLANE],
	output logic [DETW-1:0]  d_out
);
	logic en;
	logic [RW-1:0] dsh;

	assign en = !ctl_out.valid || out_ready;
	assign in_ready = en;
	assign dsh = RW'(d_in) << BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) d_out <= d_in;
	end

	// compare and subtract per lane
	for (genvar k = 0; k < NLANE; k++) begin : g_lane
		logic fits;
		assign fits = r_in[k] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				neg_out[k] <= neg_in[k];
				if (TOP) begin
					r_out[k] <= r_in[k];
					q_out[k] <= q_in[k];
					ovf_out[k] <= ovf_in[k] | fits;
				end else begin
					r_out[k] <= fits ? (r_in[k] - dsh) : r_in[k];
					q_out[k] <= q_in[k] | (fits ? (DW'(1) << BIT) : '0);
					ovf_out[k] <= ovf_in[k];
				end
			end
		end
	end
endmodule

>>> rtl/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker
// Port-level checks of the inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_defines.svh"

module m3inv_checker #(
	parameter int DW = 32
) (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input logic          out_singular,
	input logic          out_clipped,
	input logic [DW-1:0] out_inv00,
	input logic [DW-1:0] out_inv11,
	input logic [DW-1:0] out_inv22
);
	logic sing_valid;
	logic diag_zero;

	assign sing_valid = out_valid && out_singular;
	assign diag_zero = (out_inv00 == '0) && (out_inv11 == '0) && (out_inv22 == '0);

	// a singular result never reports saturation
	`M3INV_ASSERT_NOW(a_sing_noclip, !(sing_valid && out_clipped), "singular and clipped")

	// a singular result carries a zero diagonal
	`M3INV_ASSERT_NOW(a_sing_zero, !sing_valid || diag_zero, "singular result not zero")

	// an offered result stays offered until its transfer
	`M3INV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind matrix3x3_inverse m3inv_checker #(.DW(DATA_WIDTH)) u_m3inv_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out.valid),
	.out_ready   (out.ready),
	.out_singular(out.singular),
	.out_clipped (out.clipped),
	.out_inv00   (out.inv00),
	.out_inv11   (out.inv11),
	.out_inv22   (out.inv22)
);

>>> dv/matrix3x3_inverse_test.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_test
// Streams 3x3 Q16.16 matrices through the inverse pipeline. An exact
// adjugate/determinant predictor fills a scoreboard that every result
// transfer is checked against, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3x3_inverse_test;
	import m3inv_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int LATENCY = DW + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int N_RANDOM = 1250;

	typedef logic signed [DW-1:0] entry_t;
	typedef entry_t mat_t [9];

	typedef struct {
		entry_t inv [9];
		logic   singular;
		logic   clipped;
	} inverse_t;

	// exact adjugate over determinant, truncated toward zero, saturated
	function automatic inverse_t invert_matrix(mat_t a);
		inverse_t r;
		logic signed [191:0] m [3][3];
		logic signed [191:0] cof [3][3];
		logic signed [191:0] det, num, quo, lim_pos, lim_neg;
		int r1, r2, c1, c2;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = a[i*3+j];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				r1 = (i == 0) ? 1 : 0; r2 = (i == 2) ? 1 : 2;
				c1 = (j == 0) ? 1 : 0; c2 = (j == 2) ? 1 : 2;
				cof[i][j] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
				if ((i + j) % 2) cof[i][j] = -cof[i][j];
			end
		det = m[0][0]*cof[0][0] + m[1][0]*cof[1][0] + m[2][0]*cof[2][0];
		r.singular = (det == 0);
		r.clipped = 1'b0;
		lim_pos = (192'sd1 <<< (DW-1)) - 1;
		lim_neg = -(192'sd1 <<< (DW-1));
		for (int k = 0; k < 9; k++) r.inv[k] = '0;
		if (!r.singular)
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					num = cof[i][j] <<< (2*FB);
					quo = num / det; // signed division truncates toward zero
					if (quo > lim_pos) begin
						quo = lim_pos; r.clipped = 1'b1;
					end else if (quo < lim_neg) begin
						quo = lim_neg; r.clipped = 1'b1;
					end
					r.inv[j*3+i] = quo[DW-1:0];
				end
		return r;
	endfunction

	class inverse_scoreboard;
		inverse_t pending [$];
		int errors = 0;

		function void note_matrix(mat_t a);
			pending.push_back(invert_matrix(a));
		endfunction

		function void check_inverse(inverse_t got);
			inverse_t want;
			if (pending.size() == 0) begin
				$error("result transfer with no matrix outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (got.inv[k] !== want.inv[k]) begin
					$error("inv%0d%0d: expected %0d, got %0d", k/3, k%3,
						want.inv[k], got.inv[k]);
					errors++;
				end
			if (got.singular !== want.singular) begin
				$error("singular: expected %b, got %b", want.singular, got.singular);
				errors++;
			end
			if (got.clipped !== want.clipped) begin
				$error("clipped: expected %b, got %b", want.clipped, got.clipped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   idle_cycles = 0;
	inverse_scoreboard sb = new();

	m3inv_in_if  #(.DATA_WIDTH(DW)) in_ch ();
	m3inv_out_if #(.DATA_WIDTH(DW)) out_ch ();

	matrix3x3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch.sink),
		.out    (out_ch.source)
	);

	always #6 clk = ~clk;

	// drive one matrix, idle bursts before it unless in the calm tail
	task automatic send_matrix(mat_t a);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.a00 <= a[0]; in_ch.a01 <= a[1]; in_ch.a02 <= a[2];
		in_ch.a10 <= a[3]; in_ch.a11 <= a[4]; in_ch.a12 <= a[5];
		in_ch.a20 <= a[6]; in_ch.a21 <= a[7]; in_ch.a22 <= a[8];
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_matrix(a);
		@(negedge clk);
	endtask

	function automatic entry_t rand_entry(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'sh7FFFFFFF;
					1: return 32'sh80000000;
					2: return 32'sh00010000;
					3: return -32'sh00010000;
					4: return 0;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	task automatic run_directed();
		mat_t a;
		// identity, scaled identity, zero matrix
		a = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000}; send_matrix(a);
		a = '{32'sh20000, 0, 0, 0, -32'sh8000, 0, 0, 0, 32'sh40000}; send_matrix(a);
		a = '{default: 0}; send_matrix(a);
		// singular by repeated rows
		a = '{1, 2, 3, 1, 2, 3, 7, 8, 9}; send_matrix(a);
		// extremes: all max, all min, tiny determinant that clips
		a = '{default: 32'sh7FFFFFFF}; send_matrix(a);
		a = '{default: 32'sh80000000}; send_matrix(a);
		a = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
		a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
		a = '{32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh7FFFFFFF};
		send_matrix(a);
		a = '{32'sh80000000, 32'sh7FFFFFFF, 0, 0, 32'sh80000000, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 0, 32'sh80000000};
		send_matrix(a);
		// permutation and negative determinant
		a = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0, 32'sh10000}; send_matrix(a);
		a = '{32'sh18000, 32'sh4000, -32'sh2000, 32'sh1000, -32'sh30000, 32'sh800,
			32'sh10000, 32'sh10000, 32'sh10000};
		send_matrix(a);
		// full-width negation of a column, still invertible
		a = '{32'sh80000000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000}; send_matrix(a);
	endtask

	task automatic run_random();
		mat_t a;
		int mode;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n > N_RANDOM * 9 / 10) calm = 1'b1;
			mode = $urandom_range(0, 3);
			for (int k = 0; k < 9; k++) a[k] = rand_entry(mode);
			// now and then make it singular by copying a row or zeroing a column
			case ($urandom_range(0, 9))
				0: for (int k = 0; k < 3; k++) a[3+k] = a[k];
				1: for (int k = 0; k < 3; k++) a[k*3+2] = 0;
				default: ;
			endcase
			send_matrix(a);
		end
	endtask

	// result side: random stall bursts, check at the rising edge
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 16);
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		inverse_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.inv = '{out_ch.inv00, out_ch.inv01, out_ch.inv02, out_ch.inv10,
				out_ch.inv11, out_ch.inv12, out_ch.inv20, out_ch.inv21, out_ch.inv22};
			got.singular = out_ch.singular;
			got.clipped = out_ch.clipped;
			sb.check_inverse(got);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		{in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
			in_ch.a20, in_ch.a21, in_ch.a22} = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
